>>> hw/rtl/line_edit_buffer_with_history_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef LINE_EDIT_BUFFER_WITH_HISTORY_UNIT_ASSERT_SVH
`define LINE_EDIT_BUFFER_WITH_HISTORY_UNIT_ASSERT_SVH

// Checked at every rising edge outside reset.
`define LEB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LEB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/leb_pkg.sv
package leb_pkg;

  // Edit action codes carried by the action field.
  typedef enum logic [3:0] {
    ACT_INSERT    = 4'd0,
    ACT_DELETE    = 4'd1,
    ACT_BACKSPACE = 4'd2,
    ACT_LEFT      = 4'd3,
    ACT_RIGHT     = 4'd4,
    ACT_HOME      = 4'd5,
    ACT_END       = 4'd6,
    ACT_WORDLEFT  = 4'd7,
    ACT_WORDRIGHT = 4'd8,
    ACT_CLEAR     = 4'd9,
    ACT_SAVE      = 4'd10,
    ACT_OLDER     = 4'd11,
    ACT_NEWER     = 4'd12
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_LEN,
    S_PASS,
    S_PUT,
    S_READ,
    S_DONE
  } state_t;

  // Kind of streaming pass over the stored bytes.
  typedef enum logic [2:0] {
    OP_SHR,
    OP_SHL,
    OP_WL,
    OP_WR,
    OP_SAVE,
    OP_LOAD
  } op_t;

  localparam logic [7:0] SPACE = 8'h20;

endpackage

>>> hw/rtl/line_edit_buffer_with_history_unit.sv
// Line edit engine with a saved-line history.
// Input channel (in_valid/in_stall) carries one edit action per item, with the
// byte to insert and a line position to read. The output channel
// (out_valid/out_stall) returns one item per input: cursor, line length, the
// byte at read_index (zero at or past the end) and the number of saved lines.
// One item is worked at a time; in_stall is high from acceptance until the
// result has been placed in the output register. Simple moves go from the
// decode state straight to the read and done states.
// Insert, delete, backspace and word moves stream through the line memory at
// one byte a cycle. Save and recall copy the line between the line memory and
// the history memory at one byte a cycle. The single read and write port of
// each memory sets this pace.
// A new item may be accepted while the previous result waits on out_stall;
// its result is held back until the output register has been taken.
// Reset empties the line, empties the history and drops any pending result.
// No clearing pass is needed after reset: bytes at or past the line length
// are never observed.
module line_edit_buffer_with_history_unit import leb_pkg::*; #(
  parameter int LINE_LEN   = 256,
  parameter int HIST_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] action,
  input  logic [7:0] char_in,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cursor_pos,
  output logic [7:0] line_length,
  output logic [7:0] read_char,
  output logic [4:0] history_count
);

  localparam int AW   = $clog2(LINE_LEN);
  localparam int SW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CW   = $clog2(HIST_DEPTH + 1);
  localparam int PW   = $clog2(HIST_DEPTH + 2);
  localparam int HAW  = $clog2(HIST_DEPTH * LINE_LEN);
  localparam int CMPW = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] CAP = AW'(LINE_LEN - 1);

  state_t state, state_next;
  action_t act;
  logic [7:0] ch;
  logic [7:0] idx;
  logic [AW-1:0] cursor, cursor_next;
  logic [AW-1:0] length, length_next;
  logic [CW-1:0] hcnt, hcnt_next;
  logic [PW-1:0] hp1, hp1_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] slot, slot_next;
  logic [HAW-1:0] hbase, hbase_next;
  op_t op, op_next;
  logic up, up_next;
  logic wmode, wmode_next;
  logic [AW-1:0] iaddr, iaddr_next;
  logic [AW-1:0] eaddr, eaddr_next;
  logic [AW-1:0] left, left_next;
  logic pv, pv_next;
  logic out_load;

  logic line_we;
  logic [AW-1:0] line_wa, line_ra;
  logic [7:0] line_wd, line_rdata;
  logic hist_we;
  logic [HAW-1:0] hist_wa, hist_ra;
  logic [7:0] hist_rdata;
  logic len_we;
  logic [SW-1:0] len_ra;
  logic [AW-1:0] len_rdata;

  logic [SW-1:0] head_dec;
  logic [SW-1:0] tslot;
  logic [SW:0] psum;
  logic [SW-1:0] phys;
  logic [7:0] pdata;
  logic issue;
  logic fin;

  // Line, history byte and history length memories.
  leb_ram #(.DEPTH(LINE_LEN), .WIDTH(8)) u_line (
    .clk(clk), .we(line_we), .waddr(line_wa), .wdata(line_wd),
    .raddr(line_ra), .rdata(line_rdata)
  );

  leb_ram #(.DEPTH(HIST_DEPTH * LINE_LEN), .WIDTH(8)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(line_rdata),
    .raddr(hist_ra), .rdata(hist_rdata)
  );

  leb_ram #(.DEPTH(HIST_DEPTH), .WIDTH(AW)) u_hlen (
    .clk(clk), .we(len_we), .waddr(head_dec), .wdata(length),
    .raddr(len_ra), .rdata(len_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign pdata    = (op == OP_LOAD) ? hist_rdata : line_rdata;
  assign issue    = (left != '0);

  // Ring addressing: logical slot 0 is the newest line, stored at head.
  assign head_dec = (head == '0) ? SW'(HIST_DEPTH - 1) : head - SW'(1);
  always_comb begin
    tslot = SW'(hp1);
    if (act == ACT_NEWER) begin
      tslot = SW'(hp1 - PW'(2));
    end
  end
  assign psum = {1'b0, head} + {1'b0, tslot};
  assign phys = (psum >= (SW+1)'(HIST_DEPTH)) ? SW'(psum - (SW+1)'(HIST_DEPTH)) : SW'(psum);

  // Sequencer: next state and memory controls.
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    length_next = length;
    hcnt_next   = hcnt;
    hp1_next    = hp1;
    head_next   = head;
    slot_next   = slot;
    hbase_next  = hbase;
    op_next     = op;
    up_next     = up;
    wmode_next  = wmode;
    iaddr_next  = iaddr;
    eaddr_next  = eaddr;
    left_next   = left;
    pv_next     = 1'b0;
    out_load    = 1'b0;
    fin         = 1'b0;
    line_we     = 1'b0;
    line_wa     = eaddr;
    line_wd     = pdata;
    line_ra     = AW'(idx);
    hist_we     = 1'b0;
    hist_wa     = hbase + HAW'(eaddr);
    hist_ra     = hbase + HAW'(iaddr);
    len_we      = 1'b0;
    len_ra      = phys;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end

      S_DEC: begin
        state_next = S_READ;
        wmode_next = 1'b0;
        left_next  = '0;
        case (act)
          ACT_INSERT: begin
            if (ch != 8'd0) begin
              op_next = OP_SHR;
              up_next = 1'b0;
              if (length < CAP) begin
                left_next   = length - cursor;
                iaddr_next  = length - AW'(1);
                length_next = length + AW'(1);
                state_next  = S_PASS;
              end else if (cursor < length) begin
                left_next  = length - AW'(1) - cursor;
                iaddr_next = length - AW'(2);
                state_next = S_PASS;
              end
            end
          end
          ACT_DELETE: begin
            if (cursor < length) begin
              op_next     = OP_SHL;
              up_next     = 1'b1;
              left_next   = length - AW'(1) - cursor;
              iaddr_next  = cursor + AW'(1);
              length_next = length - AW'(1);
              state_next  = S_PASS;
            end
          end
          ACT_BACKSPACE: begin
            if (cursor != '0) begin
              op_next     = OP_SHL;
              up_next     = 1'b1;
              cursor_next = cursor - AW'(1);
              left_next   = length - cursor;
              iaddr_next  = cursor;
              length_next = length - AW'(1);
              state_next  = S_PASS;
            end
          end
          ACT_LEFT: begin
            if (cursor != '0) begin
              cursor_next = cursor - AW'(1);
            end
          end
          ACT_RIGHT: begin
            if (cursor < length) begin
              cursor_next = cursor + AW'(1);
            end
          end
          ACT_HOME: cursor_next = '0;
          ACT_END:  cursor_next = length;
          ACT_WORDLEFT: begin
            op_next    = OP_WL;
            up_next    = 1'b0;
            left_next  = cursor;
            iaddr_next = cursor - AW'(1);
            state_next = S_PASS;
          end
          ACT_WORDRIGHT: begin
            op_next    = OP_WR;
            up_next    = 1'b1;
            left_next  = (cursor < length) ? length - AW'(1) - cursor : '0;
            iaddr_next = cursor + AW'(1);
            state_next = S_PASS;
          end
          ACT_CLEAR: begin
            cursor_next = '0;
            length_next = '0;
          end
          ACT_SAVE: begin
            len_we     = 1'b1;
            head_next  = head_dec;
            slot_next  = head_dec;
            hcnt_next  = (hcnt == CW'(HIST_DEPTH)) ? hcnt : hcnt + CW'(1);
            op_next    = OP_SAVE;
            state_next = S_LEN;
          end
          ACT_OLDER: begin
            cursor_next = '0;
            length_next = '0;
            if (hcnt != '0 && hp1 <= PW'(hcnt)) begin
              hp1_next = hp1 + PW'(1);
              if (hp1 < PW'(hcnt)) begin
                slot_next  = phys;
                op_next    = OP_LOAD;
                state_next = S_LEN;
              end
            end
          end
          ACT_NEWER: begin
            cursor_next = '0;
            length_next = '0;
            if (hp1 <= PW'(1)) begin
              hp1_next = '0;
            end else begin
              hp1_next = hp1 - PW'(1);
              if (hp1 - PW'(2) < PW'(hcnt)) begin
                slot_next  = phys;
                op_next    = OP_LOAD;
                state_next = S_LEN;
              end
            end
          end
          default: ;
        endcase
      end

      // Length of a recalled line is ready, or a save begins; set up the copy.
      S_LEN: begin
        hbase_next = HAW'(slot) * HAW'(LINE_LEN);
        iaddr_next = '0;
        up_next    = 1'b1;
        state_next = S_PASS;
        if (op == OP_LOAD) begin
          length_next = len_rdata;
          cursor_next = len_rdata;
          left_next   = len_rdata;
        end else begin
          left_next = length;
        end
      end

      // One read issued per cycle; each byte is acted on in the next cycle.
      S_PASS: begin
        line_ra = iaddr;
        if (issue) begin
          iaddr_next = up ? iaddr + AW'(1) : iaddr - AW'(1);
          left_next  = left - AW'(1);
        end
        pv_next    = issue;
        eaddr_next = iaddr;
        if (pv) begin
          unique case (op)
            OP_SHR: begin
              line_we = 1'b1;
              line_wa = eaddr + AW'(1);
            end
            OP_SHL: begin
              line_we = 1'b1;
              line_wa = eaddr - AW'(1);
            end
            OP_SAVE: hist_we = 1'b1;
            OP_LOAD: line_we = 1'b1;
            OP_WL: begin
              if (!wmode) begin
                if (pdata != SPACE) begin
                  if (eaddr == '0) begin
                    fin         = 1'b1;
                    cursor_next = '0;
                  end else begin
                    wmode_next = 1'b1;
                  end
                end
              end else if (pdata == SPACE) begin
                fin         = 1'b1;
                cursor_next = eaddr + AW'(1);
              end
            end
            OP_WR: begin
              if (!wmode) begin
                if (pdata != SPACE) begin
                  wmode_next = 1'b1;
                end
              end else if (pdata == SPACE) begin
                fin         = 1'b1;
                cursor_next = eaddr - AW'(1);
              end
            end
            default: ;
          endcase
        end
        if (fin) begin
          state_next = S_READ;
          pv_next    = 1'b0;
          left_next  = '0;
        end else if (!issue && !pv) begin
          state_next = (op == OP_SHR) ? S_PUT : S_READ;
          if (op == OP_WL) begin
            cursor_next = '0;
          end
          if (op == OP_WR) begin
            cursor_next = length;
          end
        end
      end

      // Place the inserted byte once the tail has moved.
      S_PUT: begin
        line_we     = 1'b1;
        line_wa     = cursor;
        line_wd     = ch;
        cursor_next = cursor + AW'(1);
        state_next  = S_READ;
      end

      S_READ: state_next = S_DONE;

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      length    <= '0;
      hcnt      <= '0;
      hp1       <= '0;
      head      <= '0;
      left      <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      hcnt   <= hcnt_next;
      hp1    <= hp1_next;
      head   <= head_next;
      left   <= left_next;
      pv     <= pv_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and pass registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act <= action_t'(action);
      ch  <= char_in;
      idx <= read_index;
    end
    slot  <= slot_next;
    hbase <= hbase_next;
    op    <= op_next;
    up    <= up_next;
    wmode <= wmode_next;
    iaddr <= iaddr_next;
    eaddr <= eaddr_next;
    if (out_load) begin
      cursor_pos    <= 8'(cursor);
      line_length   <= 8'(length);
      read_char     <= (CMPW'(idx) < CMPW'(length)) ? line_rdata : 8'd0;
      history_count <= 5'(hcnt);
    end
  end

endmodule

>>> hw/rtl/leb_ram.sv
module leb_ram import leb_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/leb_check.sv
module leb_check import leb_pkg::*; #(
  parameter int LINE_LEN = 256
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [3:0] action,
  input logic [7:0] char_in,
  input logic [7:0] read_index,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cursor_pos,
  input logic [7:0] line_length,
  input logic [7:0] read_char,
  input logic [4:0] history_count
);

`include "line_edit_buffer_with_history_unit_assert.svh"

  // Reset drops any pending result.
  `LEB_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid after reset")

  // A stalled result holds all of its fields.
  `LEB_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(cursor_pos) && $stable(line_length) && $stable(read_char) && $stable(history_count), "stalled result changed")

  // The cursor never passes the end of the line.
  `LEB_ASSERT(a_cursor, (LINE_LEN > 256) || !out_valid || cursor_pos <= line_length, "cursor past end of line")

  // An empty line reads as zero.
  `LEB_ASSERT(a_empty_read, (LINE_LEN > 256) || !out_valid || line_length != 8'd0 || read_char == 8'd0, "nonzero read of empty line")

endmodule

bind line_edit_buffer_with_history_unit leb_check #(.LINE_LEN(LINE_LEN)) u_leb_check (.*);

>>> tb/line_edit_buffer_with_history_unit_checker.sv
module line_edit_buffer_with_history_unit_checker import leb_pkg::*; #(
  parameter int LINE_LEN   = 256,
  parameter int HIST_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] action,
  input  logic [7:0] char_in,
  input  logic [7:0] read_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] cursor_pos,
  input  logic [7:0] line_length,
  input  logic [7:0] read_char,
  input  logic [4:0] history_count,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = LINE_LEN - 1;

  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] len;
    logic [7:0] rd;
    logic [4:0] cnt;
  } status_t;

  // Shadow copy of the edit line and the saved lines.
  logic [7:0] line_buf [LINE_LEN];
  logic [7:0] saved_buf [HIST_DEPTH][LINE_LEN];
  int         saved_len [HIST_DEPTH];
  int         saved_num;
  int         cur;
  int         len;
  int         hptr;
  status_t    status_q [$];

  assign pending = status_q.size();

  // Recall one saved slot into the line, cursor at its end.
  task automatic recall(input int slot);
    int n;
    n = 0;
    if (slot < HIST_DEPTH && slot < saved_num) begin
      n = saved_len[slot];
      if (n > CAP) n = CAP;
    end
    for (int k = 0; k < n; k++) line_buf[k] = saved_buf[slot][k];
    len = n;
    cur = n;
  endtask

  task automatic remove_at_cursor();
    if (cur < len) begin
      for (int k = cur + 1; k < len; k++) line_buf[k-1] = line_buf[k];
      len--;
      line_buf[len] = 8'h00;
    end
  endtask

  // Apply one edit action and return the status it reports.
  task automatic edit_line(input logic [3:0] act, input logic [7:0] ch,
                           input logic [7:0] idx, output status_t res);
    int c;
    case (act)
      ACT_INSERT: begin
        if (ch != 8'h00) begin
          if (len < CAP) begin
            for (int k = len; k > cur; k--) line_buf[k] = line_buf[k-1];
            line_buf[cur] = ch;
            len++;
          end else if (cur < len) begin
            for (int k = len - 1; k > cur; k--) line_buf[k] = line_buf[k-1];
            line_buf[cur] = ch;
          end
          if (cur < len) cur++;
        end
      end
      ACT_DELETE: remove_at_cursor();
      ACT_BACKSPACE: begin
        if (cur > 0) begin
          cur--;
          remove_at_cursor();
        end
      end
      ACT_LEFT: if (cur > 0) cur--;
      ACT_RIGHT: if (cur < len) cur++;
      ACT_HOME: cur = 0;
      ACT_END: cur = len;
      ACT_WORDLEFT: begin
        c = cur;
        while (c > 0) begin
          c--;
          if (line_buf[c] != SPACE) break;
        end
        if (c != 0) begin
          while (c > 0) begin
            c--;
            if (line_buf[c] == SPACE) break;
          end
          if (line_buf[c] == SPACE) c++;
        end
        cur = c;
      end
      ACT_WORDRIGHT: begin
        c = cur;
        while (c < len) begin
          c++;
          if (c >= len || line_buf[c] != SPACE) break;
        end
        if (c < len) begin
          while (c < len) begin
            c++;
            if (c >= len || line_buf[c] == SPACE) break;
          end
          if (c < len && line_buf[c] == SPACE) c--;
        end
        cur = c;
      end
      ACT_CLEAR: begin
        cur = 0;
        len = 0;
      end
      ACT_SAVE: begin
        for (int n = HIST_DEPTH - 1; n > 0; n--) begin
          saved_buf[n] = saved_buf[n-1];
          saved_len[n] = saved_len[n-1];
        end
        saved_buf[0] = line_buf;
        saved_len[0] = len;
        if (saved_num < HIST_DEPTH) saved_num++;
      end
      ACT_OLDER: begin
        cur = 0;
        len = 0;
        if (saved_num > 0 && hptr < HIST_DEPTH && !(hptr >= 0 && hptr >= saved_num))
        begin
          hptr++;
          if (hptr < HIST_DEPTH && hptr < saved_num) recall(hptr);
        end
      end
      ACT_NEWER: begin
        if (hptr <= 0) begin
          hptr = -1;
          cur = 0;
          len = 0;
        end else begin
          hptr--;
          recall(hptr);
        end
      end
      default: ;
    endcase
    res.cur = cur[7:0];
    res.len = len[7:0];
    res.rd  = (int'(idx) < len) ? line_buf[idx] : 8'h00;
    res.cnt = saved_num[4:0];
  endtask

  // Predict on each accepted input item, compare on each accepted result.
  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (rst) begin
      for (int k = 0; k < LINE_LEN; k++) line_buf[k] = 8'h00;
      cur = 0;
      len = 0;
      saved_num = 0;
      hptr = -1;
      fail_count = 0;
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{cursor_pos, line_length, read_char, history_count};
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (got.cur != want.cur) begin
            $display("%0t: cursor_pos expected %0d actual %0d", $time, want.cur, got.cur);
            fail_count++;
          end
          if (got.len != want.len) begin
            $display("%0t: line_length expected %0d actual %0d", $time, want.len, got.len);
            fail_count++;
          end
          if (got.rd != want.rd) begin
            $display("%0t: read_char expected %h actual %h", $time, want.rd, got.rd);
            fail_count++;
          end
          if (got.cnt != want.cnt) begin
            $display("%0t: history_count expected %0d actual %0d", $time, want.cnt,
                     got.cnt);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        edit_line(action, char_in, read_index, want);
        status_q.push_back(want);
      end
    end
  end
endmodule

>>> tb/line_edit_buffer_with_history_unit_tb.sv
module line_edit_buffer_with_history_unit_tb import leb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] action;
  logic [7:0] char_in;
  logic [7:0] read_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] cursor_pos;
  logic [7:0] line_length;
  logic [7:0] read_char;
  logic [4:0] history_count;
  int         fail_count;
  int         pending;
  bit         hold_off;

  line_edit_buffer_with_history_unit uut (.*);
  line_edit_buffer_with_history_unit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(300);
  endfunction

  // Offer one item and wait for acceptance.
  task automatic send_item(input logic [3:0] act, input logic [7:0] ch,
                           input logic [7:0] idx);
    action     <= act;
    char_in    <= ch;
    read_index <= idx;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Mostly typing with spaces, plus moves and history use.
  task automatic random_item();
    int r;
    logic [7:0] ch;
    logic [3:0] act;
    r = $urandom_range(99);
    ch = ($urandom_range(3) == 0) ? SPACE : 8'($urandom_range(255));
    if (r < 40) act = ACT_INSERT;
    else if (r < 94) act = 4'($urandom_range(12));
    else act = 4'($urandom_range(15));
    send_item(act, ch, 8'($urandom));
  endtask

  // Receiver side: stall gaps of random length, and one long hold-off on request.
  initial begin
    int g;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        g = gap_len();
        out_stall <= (g > 0);
        if (g > 1) repeat (g - 1) @(posedge clk);
      end
    end
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_INSERT;
    char_in = 8'h41;
    read_index = 8'h00;
    hold_off = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: history on empty, every action, zero byte, bad codes.
    send_item(ACT_OLDER, 8'h01, 8'h00);
    send_item(ACT_NEWER, 8'h01, 8'hFF);
    send_item(ACT_INSERT, 8'h00, 8'h00);
    send_item(ACT_INSERT, 8'hFF, 8'h00);
    send_item(ACT_INSERT, SPACE, 8'h01);
    send_item(ACT_INSERT, 8'h01, 8'h02);
    send_item(ACT_INSERT, 8'h80, 8'h02);
    send_item(ACT_WORDLEFT, 8'h01, 8'h00);
    send_item(ACT_WORDRIGHT, 8'h01, 8'h01);
    send_item(ACT_LEFT, 8'h01, 8'h03);
    send_item(ACT_BACKSPACE, 8'h01, 8'h01);
    send_item(ACT_HOME, 8'h01, 8'h00);
    send_item(ACT_DELETE, 8'h01, 8'h00);
    send_item(ACT_END, 8'h01, 8'h00);
    send_item(ACT_RIGHT, 8'h01, 8'h00);
    send_item(ACT_SAVE, 8'h01, 8'h00);
    send_item(ACT_CLEAR, 8'h01, 8'h00);
    send_item(ACT_OLDER, 8'h01, 8'h00);
    send_item(ACT_OLDER, 8'h01, 8'h00);
    send_item(ACT_NEWER, 8'h01, 8'h00);
    send_item(4'd13, 8'h01, 8'h00);
    send_item(4'd15, 8'h01, 8'h00);

    // Fill the line to capacity, insert while full, save it repeatedly and step through the history.
    for (int k = 0; k < 260; k++) send_item(ACT_INSERT, 8'($urandom_range(1, 255)),
                                            8'($urandom));
    send_item(ACT_HOME, 8'h01, 8'hFE);
    send_item(ACT_INSERT, 8'h55, 8'hFE);
    for (int k = 0; k < 18; k++) send_item(ACT_SAVE, 8'h01, 8'($urandom));
    for (int k = 0; k < 18; k++) send_item(ACT_OLDER, 8'h01, 8'($urandom));
    for (int k = 0; k < 18; k++) send_item(ACT_NEWER, 8'h01, 8'($urandom));
    send_item(ACT_CLEAR, 8'h01, 8'h00);

    // Long receiver hold-off while items keep coming.
    hold_off = 1'b1;
    for (int k = 0; k < 20; k++) random_item();

    for (int k = 0; k < 880; k++) begin
      random_item();
      pause_sender();
      if (k % 150 == 0) send_item(ACT_CLEAR, 8'h01, 8'h00);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> line_edit_buffer_with_history_unit.f
+incdir+hw/rtl
hw/rtl/leb_pkg.sv
hw/rtl/leb_ram.sv
hw/rtl/line_edit_buffer_with_history_unit.sv
hw/rtl/leb_check.sv
tb/line_edit_buffer_with_history_unit_checker.sv
tb/line_edit_buffer_with_history_unit_tb.sv
